>>> design/scc_pkg.sv
// Shared types, constants and mapping functions for the strip channel to
// local coordinate converter. No dependencies.
package scc_pkg;

    // Channel position format
    localparam int FRAC_BITS   = 8;
    localparam int POS_W       = 18;
    localparam int CH_W        = POS_W - FRAC_BITS + 1;
    localparam int FRAC_W      = FRAC_BITS + 1;

    // Geometry constants
    localparam int READ_STRIPS = 384;
    localparam int S_LAST      = 639;
    localparam int K_FIRST     = 640;
    localparam int K_LAST      = 1023;
    localparam int K5_GAP      = 191;
    localparam int K5_HALF     = 192;
    localparam int K7_GROUP_A  = 64;
    localparam int K7_GROUP_B  = 160;
    localparam int K7_GROUP_C  = 224;

    // Field widths
    localparam int PITCH_W     = 16;
    localparam int SPK_W       = 20;
    localparam int MULT_W      = 4;
    localparam int COORD_W     = 24;
    localparam int H_W         = 12;
    localparam int PROD_W      = H_W + PITCH_W;
    localparam int PS_W        = SPK_W + MULT_W;
    localparam int C1_W        = PROD_W + 1;
    localparam int FD_W        = FRAC_W + C1_W;
    localparam int ACC_W       = FD_W + 2;

    // Multiplicity limit: span is 3 << DEN_SHIFT
    localparam int MX_W        = 23;
    localparam int DEN_SHIFT   = FRAC_BITS + 7;
    localparam int MULT_MAX    = 15;

    // Configuration register indexes
    localparam int CFG_IDX_W   = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_S         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_K5        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMPLANT_PITCH_K = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_PITCH_K  = 3'd3;

    typedef enum logic [1:0] {
        SIDE_S,
        SIDE_K5,
        SIDE_K7
    } side_t;

    // Decode stage to multiply stage
    typedef struct packed {
        logic                     ok;
        logic [MULT_W-1:0]        mult;
        logic signed [FRAC_W-1:0] frac;
        side_t                    side;
        logic [H_W-1:0]           h1;
        logic [H_W-1:0]           h2;
    } dec_t;

    // First product stage
    typedef struct packed {
        logic                     ok;
        logic [MULT_W-1:0]        mult;
        logic signed [FRAC_W-1:0] frac;
        logic [PROD_W-1:0]        p1;
        logic [PROD_W-1:0]        pd;
        logic [PS_W-1:0]          ps;
    } prod_t;

    // Second product stage
    typedef struct packed {
        logic                   ok;
        logic [MULT_W-1:0]      mult;
        logic [C1_W-1:0]        c1;
        logic signed [FD_W-1:0] fd;
    } acc_t;

    // K7 implant strip index for a readout strip within a sensor
    function automatic logic [9:0] implant_strip(input logic [9:0] rs);
        logic [9:0] odd2;
        logic [9:0] pair3;
        odd2  = {8'd0, rs[0], 1'b0};
        pair3 = 10'({1'b0, rs[9:1]} * 10'd3);
        if (rs < 10'(K7_GROUP_A))
            return odd2 + pair3;
        else if (rs < 10'(K7_GROUP_B))
            return 10'd96 + {rs - 10'(K7_GROUP_A)} * 10'd2;
        else if (rs < 10'(K7_GROUP_C))
            return 10'd48 + odd2 + pair3;
        else
            return 10'd0;
    endfunction

    // Channel coordinate over pitch, in half pitch units
    function automatic logic [H_W-1:0] chan_half(input logic [CH_W-1:0] c,
                                                 input side_t side);
        logic [CH_W-1:0] cc;
        logic [9:0]      ch;
        logic [9:0]      ch2;
        cc  = c + CH_W'(c != '0) + CH_W'(c == CH_W'(S_LAST));
        ch  = c[9:0] - 10'(K_FIRST);
        ch2 = (ch > 10'(K5_GAP)) ? ch - 10'(K5_HALF) : ch;
        case (side)
            SIDE_S:  return {cc, 1'b0};
            SIDE_K5: return H_W'({ch2, 1'b0}) + H_W'(ch2 == 10'(K5_GAP));
            SIDE_K7: return H_W'({implant_strip(ch), 1'b0});
            default: return '0;
        endcase
    endfunction

    // Channel range check for a side
    function automatic logic chan_ok(input logic signed [CH_W:0] v,
                                     input side_t side);
        if (side == SIDE_S)
            return (v >= 0) && (v <= (CH_W+1)'(S_LAST));
        else
            return (v >= (CH_W+1)'(K_FIRST)) && (v <= (CH_W+1)'(K_LAST));
    endfunction

endpackage

>>> design/scc_decode.sv
// Stage 1: multiplicity limit, channel rounding, side select, range checks
// and strip index lookup. Depends on scc_pkg.
module scc_decode (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [scc_pkg::POS_W-1:0]   channel_pos,
    input  logic [3:0]                  layer_id,
    input  logic [3:0]                  sensor_count,
    input  logic signed [4:0]           multiplicity,
    output logic                        out_valid,
    output scc_pkg::dec_t               out_dec
);
    import scc_pkg::*;

    logic                      valid_reg;
    dec_t                      dec_reg;
    dec_t                      dec_next;

    logic                      k7;
    logic                      above;
    logic signed [MX_W-1:0]    mx;
    logic [MX_W-1:0]           mx_u;
    logic [7:0]                t;
    logic [13:0]               q;
    logic [MULT_W-1:0]         mmax;
    logic [POS_W:0]            pos_rnd;
    logic [CH_W-1:0]           c;
    logic signed [CH_W:0]      n;
    side_t                     side;

    // Ladder maximum: ceil(num / span) - 1 = floor((num - 1) / span)
    always_comb
    begin
        k7    = (layer_id == 4'd1) || (layer_id == 4'd8);
        above = channel_pos > POS_W'(S_LAST * (2 ** FRAC_BITS));
        mx    = $signed(MX_W'(sensor_count) * MX_W'(READ_STRIPS * (2 ** FRAC_BITS)))
              + $signed(MX_W'(K_FIRST * (2 ** FRAC_BITS)))
              - $signed(MX_W'(channel_pos)) - $signed(MX_W'(1));
        mx_u  = mx;
        t     = 8'(mx_u >> DEN_SHIFT);
        q     = (14'(t) * 14'd43) >> 7;   // divide by three
        if (!above || mx < 0)
            mmax = '0;
        else if (q > 14'(MULT_MAX))
            mmax = MULT_W'(MULT_MAX);
        else
            mmax = q[MULT_W-1:0];
    end

    // Rounding, neighbor and side
    always_comb
    begin
        pos_rnd = {1'b0, channel_pos} + (POS_W+1)'(2 ** (FRAC_BITS - 1));
        c       = pos_rnd[POS_W:FRAC_BITS];
        n       = $signed({1'b0, c}) + (channel_pos[FRAC_BITS-1] ?
                  -$signed((CH_W+1)'(1)) : $signed((CH_W+1)'(1)));
        if (channel_pos < POS_W'(K_FIRST * (2 ** FRAC_BITS)))
            side = SIDE_S;
        else if (k7)
            side = SIDE_K7;
        else
            side = SIDE_K5;

        dec_next.side = side;
        dec_next.ok   = chan_ok($signed({1'b0, c}), side) && chan_ok(n, side);
        dec_next.frac = $signed({channel_pos[FRAC_BITS-1],
                                 channel_pos[FRAC_BITS-1:0]});
        dec_next.h1   = chan_half(c, side);
        dec_next.h2   = chan_half(n[CH_W-1:0], side);
        if (multiplicity < 0 || {1'b0, multiplicity[MULT_W-1:0]} > {1'b0, mmax})
            dec_next.mult = mmax;
        else
            dec_next.mult = multiplicity[MULT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        dec_reg <= dec_next;
    end

    assign out_valid = valid_reg;
    assign out_dec   = dec_reg;

endmodule

>>> design/scc_mult.sv
// Stages 2 and 3: pitch products, sensor offset and interpolation product.
// Depends on scc_pkg.
module scc_mult (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  scc_pkg::dec_t              in_dec,
    input  logic [scc_pkg::PITCH_W-1:0] pitch_s,
    input  logic [scc_pkg::PITCH_W-1:0] pitch_k5,
    input  logic [scc_pkg::PITCH_W-1:0] implant_pitch_k,
    input  logic [scc_pkg::SPK_W-1:0]   sensor_pitch_k,
    output logic                       out_valid,
    output scc_pkg::acc_t              out_acc
);
    import scc_pkg::*;

    logic               v2_reg;
    logic               v3_reg;
    prod_t              prod_reg;
    prod_t              prod_next;
    acc_t               acc_reg;
    acc_t               acc_next;
    logic [PITCH_W-1:0] pitch;
    logic [H_W-1:0]     dh;

    // Stage 2: pitch select and the three products
    always_comb
    begin
        case (in_dec.side)
            SIDE_S:  pitch = pitch_s;
            SIDE_K5: pitch = pitch_k5;
            SIDE_K7: pitch = implant_pitch_k;
            default: pitch = pitch_s;
        endcase
        dh = (in_dec.h1 >= in_dec.h2) ? in_dec.h1 - in_dec.h2 : in_dec.h2 - in_dec.h1;
        prod_next.ok   = in_dec.ok;
        prod_next.mult = in_dec.mult;
        prod_next.frac = in_dec.frac;
        prod_next.p1   = PROD_W'(in_dec.h1) * PROD_W'(pitch);
        prod_next.pd   = PROD_W'(dh) * PROD_W'(pitch);
        prod_next.ps   = (in_dec.side == SIDE_S) ? '0
                       : PS_W'(sensor_pitch_k) * PS_W'(in_dec.mult);
    end

    // Stage 3: channel coordinate and fraction times neighbor distance
    always_comb
    begin
        acc_next.ok   = prod_reg.ok;
        acc_next.mult = prod_reg.mult;
        acc_next.c1   = (C1_W'(prod_reg.ps) << 1) + C1_W'(prod_reg.p1);
        // full width signed product, both operands extended to FD_W
        acc_next.fd   = $signed({{(FD_W-FRAC_W){prod_reg.frac[FRAC_W-1]}}, prod_reg.frac})
                      * $signed({{(FD_W-PROD_W){1'b0}}, prod_reg.pd});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= in_valid;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    assign out_valid = v3_reg;
    assign out_acc   = acc_reg;

endmodule

>>> design/scc_round.sv
// Stage 4: interpolation sum, rounding to 0.1 um, saturation and the
// output registers. Depends on scc_pkg.
module scc_round (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  scc_pkg::acc_t                in_acc,
    output logic                         done,
    output logic [scc_pkg::COORD_W-1:0]  local_coord,
    output logic                         invalid,
    output logic [scc_pkg::MULT_W-1:0]   used_multiplicity
);
    import scc_pkg::*;

    logic                      done_reg;
    logic [COORD_W-1:0]        coord_reg;
    logic [COORD_W-1:0]        coord_next;
    logic                      invalid_reg;
    logic [MULT_W-1:0]         mult_reg;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   res;

    // Round half up at FRAC_BITS+1 and clamp
    always_comb
    begin
        acc = $signed(ACC_W'(in_acc.c1) << FRAC_BITS)
            + $signed({{(ACC_W-FD_W){in_acc.fd[FD_W-1]}}, in_acc.fd});
        res = (acc + $signed(ACC_W'(2 ** FRAC_BITS))) >>> (FRAC_BITS + 1);
        if (!in_acc.ok || res < 0)
            coord_next = '0;
        else if (res > $signed(ACC_W'({COORD_W{1'b1}})))
            coord_next = '1;
        else
            coord_next = res[COORD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        coord_reg   <= coord_next;
        invalid_reg <= !in_acc.ok;
        mult_reg    <= in_acc.mult;
    end

    assign done              = done_reg;
    assign local_coord       = coord_reg;
    assign invalid           = invalid_reg;
    assign used_multiplicity = mult_reg;

endmodule

>>> design/strip_channel_to_local_coord_top.sv
// Top level of the strip channel to local coordinate converter: register
// file, pipeline stages and checks. Depends on scc_pkg, scc_decode,
// scc_mult and scc_round.

// A new channel is taken on every clock where start is high; busy is always
// low. Each transaction produces one result, shown for one cycle with done
// high, after the four-stage pipeline (decode, pitch products, interpolation
// product, rounding). The receiver cannot stall. Register writes are always
// accepted (cfg_ready is always high) and must only be issued while no
// transaction is in flight.
module strip_channel_to_local_coord_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [scc_pkg::POS_W-1:0]      channel_pos,
    input  logic [3:0]                     layer_id,
    input  logic [3:0]                     sensor_count,
    input  logic signed [4:0]              multiplicity,
    output logic                           done,
    output logic [scc_pkg::COORD_W-1:0]    local_coord,
    output logic                           invalid,
    output logic [scc_pkg::MULT_W-1:0]     used_multiplicity,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [scc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [scc_pkg::SPK_W-1:0]      cfg_data
);
    import scc_pkg::*;

    logic [PITCH_W-1:0] pitch_s_reg;
    logic [PITCH_W-1:0] pitch_k5_reg;
    logic [PITCH_W-1:0] implant_pitch_k_reg;
    logic [SPK_W-1:0]   sensor_pitch_k_reg;
    logic               dec_valid;
    dec_t               dec;
    logic               acc_valid;
    acc_t               acc;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_s_reg         <= 16'd1100;
            pitch_k5_reg        <= 16'd2080;
            implant_pitch_k_reg <= 16'd1040;
            sensor_pitch_k_reg  <= 20'd414000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PITCH_S:         pitch_s_reg         <= cfg_data[PITCH_W-1:0];
                CFG_PITCH_K5:        pitch_k5_reg        <= cfg_data[PITCH_W-1:0];
                CFG_IMPLANT_PITCH_K: implant_pitch_k_reg <= cfg_data[PITCH_W-1:0];
                CFG_SENSOR_PITCH_K:  sensor_pitch_k_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    scc_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start && !busy),
        .channel_pos  (channel_pos),
        .layer_id     (layer_id),
        .sensor_count (sensor_count),
        .multiplicity (multiplicity),
        .out_valid    (dec_valid),
        .out_dec      (dec)
    );

    scc_mult u_mult (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (dec_valid),
        .in_dec          (dec),
        .pitch_s         (pitch_s_reg),
        .pitch_k5        (pitch_k5_reg),
        .implant_pitch_k (implant_pitch_k_reg),
        .sensor_pitch_k  (sensor_pitch_k_reg),
        .out_valid       (acc_valid),
        .out_acc         (acc)
    );

    scc_round u_round (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (acc_valid),
        .in_acc            (acc),
        .done              (done),
        .local_coord       (local_coord),
        .invalid           (invalid),
        .used_multiplicity (used_multiplicity)
    );

    // Every result strobe follows an accepted transaction
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 4))
        else $error("result without matching transaction");

    // Every accepted transaction yields a result
    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##4 done)
        else $error("transaction lost in pipeline");

    // An invalid result carries a zero coordinate
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && invalid) |-> (local_coord == '0))
        else $error("invalid result with nonzero coordinate");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for strip_channel_to_local_coord_top: drives channel
// transactions and register writes, predicts each result, checks it on done.
// Depends on scc_pkg and the converter RTL.
module tb_top;
    import scc_pkg::*;

    // Expected result of one transaction
    typedef struct {
        logic [COORD_W-1:0] coord;
        logic               bad;
        logic [MULT_W-1:0]  mult;
    } coord_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    logic [POS_W-1:0]       channel_pos;
    logic [3:0]             layer_id;
    logic [3:0]             sensor_count;
    logic signed [4:0]      multiplicity;
    logic                   done;
    logic [COORD_W-1:0]     local_coord;
    logic                   invalid;
    logic [MULT_W-1:0]      used_multiplicity;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [SPK_W-1:0]       cfg_data;

    // Shadow copy of the register file
    logic [15:0]            pitch_s_q;
    logic [15:0]            pitch_k5_q;
    logic [15:0]            implant_pitch_q;
    logic [19:0]            sensor_pitch_q;

    coord_result_t          pending_coords[$];
    int                     error_count;

    strip_channel_to_local_coord_top i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .channel_pos       (channel_pos),
        .layer_id          (layer_id),
        .sensor_count      (sensor_count),
        .multiplicity      (multiplicity),
        .done              (done),
        .local_coord       (local_coord),
        .invalid           (invalid),
        .used_multiplicity (used_multiplicity),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #8000000;
        $display("Mismatches found");
        $finish;
    end

    // K7 implant strip for a strip index within a sensor
    function automatic longint implant_index(input longint rs);
        longint odd;
        odd = rs & 1;
        if (rs < 0) return 0;
        if (rs < K7_GROUP_A) return 2 * odd + ((rs - odd) / 2) * 3;
        if (rs < K7_GROUP_B) return 96 + (rs - K7_GROUP_A) * 2;
        if (rs < K7_GROUP_C) return 48 + 2 * odd + ((rs - odd) / 2) * 3;
        return 0;
    endfunction

    // Coordinate of channel c in 0.05 um; 0 returned when out of range
    function automatic bit channel_half_um(input longint c, input side_t side,
                                           input longint mult, output longint half);
        longint v;
        longint ch;
        longint ch2;
        longint sensor;
        longint tot;
        half = 0;
        if (side == SIDE_S)
        begin
            if (c < 0 || c > S_LAST) return 0;
            v = c * longint'(pitch_s_q);
            if (c != 0) v += pitch_s_q;
            if (c == S_LAST) v += pitch_s_q;
            half = 2 * v;
            return 1;
        end
        if (c < K_FIRST || c > K_LAST) return 0;
        ch = c - K_FIRST;
        tot = ch + mult * READ_STRIPS;
        sensor = tot / READ_STRIPS;
        if (side == SIDE_K5)
        begin
            ch2 = (ch > K5_GAP) ? ch - K5_HALF : ch;
            v = 2 * (longint'(sensor_pitch_q) * sensor + ch2 * longint'(pitch_k5_q));
            if (ch2 == K5_GAP) v += pitch_k5_q;
            half = v;
        end
        else
            half = 2 * (longint'(sensor_pitch_q) * sensor +
                        implant_index(tot - sensor * READ_STRIPS) *
                        longint'(implant_pitch_q));
        return 1;
    endfunction

    // Predicted result for one channel transaction
    function automatic coord_result_t predict_coord(input logic [POS_W-1:0] pos_in,
                                                    input logic [3:0] lay,
                                                    input logic [3:0] nsens,
                                                    input logic signed [4:0] req_in);
        coord_result_t r;
        longint one;
        longint pos;
        longint req;
        longint num;
        longint mmax;
        longint mult;
        longint c;
        longint frac;
        longint c1;
        longint c2;
        longint diff;
        longint acc;
        longint res;
        bit     k7;
        bit     ok;
        side_t  side;
        one  = 1 << FRAC_BITS;
        pos  = pos_in;
        req  = req_in;
        k7   = (lay == 1 || lay == 8);
        if (pos <= S_LAST * one)
            mmax = 0;
        else
        begin
            num  = longint'(nsens) * READ_STRIPS * one + K_FIRST * one - pos;
            // ceiling division minus one
            if (num > 0)
                mmax = (num + READ_STRIPS * one - 1) / (READ_STRIPS * one) - 1;
            else
                mmax = -((-num) / (READ_STRIPS * one)) - 1;
        end
        if (mmax < 0) mmax = 0;
        if (mmax > MULT_MAX) mmax = MULT_MAX;
        mult = (req > mmax || req < 0) ? mmax : req;
        c    = (pos + (one >> 1)) >> FRAC_BITS;
        frac = pos - c * one;
        if (pos < K_FIRST * one) side = SIDE_S;
        else side = k7 ? SIDE_K7 : SIDE_K5;
        ok = channel_half_um(c, side, mult, c1);
        ok = channel_half_um(frac >= 0 ? c + 1 : c - 1, side, mult, c2) && ok;
        res = 0;
        if (ok)
        begin
            diff = (c1 > c2) ? c1 - c2 : c2 - c1;
            acc  = c1 * one + frac * diff + one;
            res  = (acc >= 0) ? acc / (2 * one) : -((-acc + 2 * one - 1) / (2 * one));
            if (res < 0) res = 0;
            if (res > 16777215) res = 16777215;
        end
        r.coord = res[COORD_W-1:0];
        r.bad   = !ok;
        r.mult  = mult[MULT_W-1:0];
        return r;
    endfunction

    // Result checker, sampled away from the driving edge
    always @(negedge clk)
    begin
        coord_result_t e;
        if (rst_n && done)
        begin
            if (pending_coords.size() == 0)
            begin
                $display("%0t: result with none expected: coord %0d invalid %0b mult %0d",
                         $time, local_coord, invalid, used_multiplicity);
                error_count++;
            end
            else
            begin
                e = pending_coords.pop_front();
                if (local_coord !== e.coord)
                begin
                    $display("%0t: local_coord expected %0d actual %0d",
                             $time, e.coord, local_coord);
                    error_count++;
                end
                if (invalid !== e.bad)
                begin
                    $display("%0t: invalid expected %0b actual %0b",
                             $time, e.bad, invalid);
                    error_count++;
                end
                if (used_multiplicity !== e.mult)
                begin
                    $display("%0t: used_multiplicity expected %0d actual %0d",
                             $time, e.mult, used_multiplicity);
                    error_count++;
                end
            end
        end
    end

    // Send one channel transaction, then an optional random gap
    task automatic send_channel(input logic [POS_W-1:0] pos, input logic [3:0] lay,
                                input logic [3:0] nsens, input logic signed [4:0] req);
        int pick;
        int gap;
        start        <= 1'b1;
        channel_pos  <= pos;
        layer_id     <= lay;
        sensor_count <= nsens;
        multiplicity <= req;
        forever
        begin
            @(negedge clk);
            if (!busy) break;
            @(posedge clk);
        end
        @(posedge clk);
        pending_coords.push_back(predict_coord(pos, lay, nsens, req));
        pick = $urandom_range(0, 99);
        if (pick < 50) gap = 0;
        else if (pick < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 30);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Wait until every expected result has come, then let the pipeline empty
    task automatic drain_pipe();
        start <= 1'b0;
        @(posedge clk);
        while (pending_coords.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Register write on the configuration channel, only while idle;
    // the caller drops cfg_valid after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SPK_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        forever
        begin
            @(negedge clk);
            if (cfg_ready) break;
            @(posedge clk);
        end
        @(posedge clk);
        case (idx)
            CFG_PITCH_S:         pitch_s_q       = val[15:0];
            CFG_PITCH_K5:        pitch_k5_q      = val[15:0];
            CFG_IMPLANT_PITCH_K: implant_pitch_q = val[15:0];
            CFG_SENSOR_PITCH_K:  sensor_pitch_q  = val;
            default: ;
        endcase
    endtask

    task automatic load_geometry(input logic [SPK_W-1:0] ps, input logic [SPK_W-1:0] pk5,
                                 input logic [SPK_W-1:0] ipk, input logic [SPK_W-1:0] spk);
        drain_pipe();
        write_reg(CFG_PITCH_S, ps);
        write_reg(CFG_PITCH_K5, pk5);
        write_reg(CFG_IMPLANT_PITCH_K, ipk);
        write_reg(CFG_SENSOR_PITCH_K, spk);
        cfg_valid <= 1'b0;
    endtask

    // Directed: range edges, rounding, neighbors, multiplicity clamps, K7 table
    task automatic test_directed();
        send_channel(18'd0, 4'd2, 4'd1, 5'sd0);
        send_channel(18'd127, 4'd2, 4'd1, 5'sd0);
        send_channel(18'd128, 4'd2, 4'd1, 5'sd0);
        send_channel(18'd200, 4'd2, 4'd1, 5'sd0);
        send_channel(18'(639 * 256), 4'd2, 4'd1, 5'sd0);
        send_channel(18'(638 * 256 + 200), 4'd2, 4'd1, 5'sd0);
        send_channel(18'(639 * 256 + 130), 4'd2, 4'd1, 5'sd0);
        send_channel(18'(640 * 256), 4'd3, 4'd15, 5'sd2);
        send_channel(18'(640 * 256), 4'd1, 4'd15, 5'sd2);
        send_channel(18'(640 * 256 + 100), 4'd3, 4'd4, -5'sd1);
        send_channel(18'(831 * 256 + 60), 4'd3, 4'd4, 5'sd1);
        send_channel(18'(832 * 256 + 10), 4'd3, 4'd4, 5'sd15);
        send_channel(18'(703 * 256 + 90), 4'd8, 4'd6, 5'sd3);
        send_channel(18'(800 * 256 + 20), 4'd8, 4'd6, -5'sd16);
        send_channel(18'(863 * 256 + 255), 4'd1, 4'd2, 5'sd1);
        send_channel(18'(900 * 256), 4'd1, 4'd15, 5'sd15);
        send_channel(18'(1023 * 256), 4'd3, 4'd9, 5'sd0);
        send_channel(18'h3FFFF, 4'd9, 4'd15, 5'sd7);
        send_channel(18'(1022 * 256 + 127), 4'd0, 4'd0, 5'sd5);
        send_channel(18'(700 * 256), 4'd15, 4'd0, 5'sd1);
    endtask

    // Random: positions weighted toward the interesting regions
    task automatic test_random(input int count);
        logic [POS_W-1:0] pos;
        int               region;
        repeat (count)
        begin
            region = $urandom_range(0, 9);
            case (region)
                0:       pos = POS_W'($urandom_range(0, 1023));
                1:       pos = POS_W'($urandom_range(637 * 256, 641 * 256));
                2:       pos = POS_W'($urandom_range(1021 * 256, 262143));
                3, 4:    pos = POS_W'($urandom_range(0, 640 * 256 - 1));
                default: pos = POS_W'($urandom_range(640 * 256, 262143));
            endcase
            send_channel(pos, ($urandom_range(0, 3) == 0) ? 4'($urandom) :
                         (($urandom_range(0, 1) == 0) ? 4'd1 : 4'd8) ^
                         4'($urandom_range(0, 1) * 6),
                         4'($urandom), 5'($urandom));
        end
    endtask

    task automatic test_geometry_sets();
        load_geometry(20'd0, 20'd0, 20'd0, 20'd0);
        test_random(150);
        load_geometry(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
        test_directed();
        test_random(200);
        load_geometry(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom));
        test_random(200);
        load_geometry(20'd1100, 20'd2080, 20'd1040, 20'd414000);
        test_random(200);
    endtask

    // Main sequence
    initial
    begin
        error_count     = 0;
        rst_n           = 1'b0;
        start           = 1'b0;
        channel_pos     = '0;
        layer_id        = '0;
        sensor_count    = '0;
        multiplicity    = '0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        pitch_s_q       = 16'd1100;
        pitch_k5_q      = 16'd2080;
        implant_pitch_q = 16'd1040;
        sensor_pitch_q  = 20'd414000;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(300);
        test_geometry_sets();
        drain_pipe();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Leftover expectations count as failures at the end
    always @(posedge clk)
    begin
        if (rst_n && !start && pending_coords.size() > 0 && $time > 7999000)
            error_count++;
    end

endmodule

>>> files.f
design/scc_pkg.sv
design/scc_decode.sv
design/scc_mult.sv
design/scc_round.sv
design/strip_channel_to_local_coord_top.sv
tb/tb_top.sv
